// ===== rtl/i2r_pkg.sv =====
// Package for the infix to reverse Polish converter.
// Token codes, error codes, precedence table, sequencer states and shared structs.
// No dependencies; imported by every module of the block.
package i2r_pkg;

   localparam int STACK_DEPTH_DEF = 32;

   // stream widths
   localparam int REQ_TDATA_W = 88;
   localparam int REQ_TUSER_W = 4;
   localparam int RSP_TDATA_W = 88;
   localparam int RSP_TUSER_W = 5;

   // input actions
   localparam logic [3:0] ACT_NUMBER = 4'd0;
   localparam logic [3:0] ACT_VAR    = 4'd1;
   localparam logic [3:0] ACT_FUNC   = 4'd2;
   localparam logic [3:0] ACT_OP     = 4'd3;
   localparam logic [3:0] ACT_OPEN   = 4'd4;
   localparam logic [3:0] ACT_CLOSE  = 4'd5;
   localparam logic [3:0] ACT_COMMA  = 4'd6;
   localparam logic [3:0] ACT_END    = 4'd7;
   localparam logic [3:0] ACT_CUSTOM = 4'd8;

   localparam logic [2:0] OP_MAX = 3'd4;

   // RPN token codes; an open marker on the stack uses code zero
   localparam logic [3:0] RPN_CONST     = 4'd0;
   localparam logic [3:0] RPN_VAR       = 4'd1;
   localparam logic [3:0] RPN_CUSTOM    = 4'd2;
   localparam logic [3:0] RPN_ADD       = 4'd3;
   localparam logic [3:0] RPN_SUB       = 4'd4;
   localparam logic [3:0] RPN_MUL       = 4'd5;
   localparam logic [3:0] RPN_DIV       = 4'd6;
   localparam logic [3:0] RPN_POW       = 4'd7;
   localparam logic [3:0] RPN_FUNC_BASE = 4'd8;
   localparam logic [3:0] MARKER        = 4'd0;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_OPERATOR = 3'd1;
   localparam logic [2:0] ERR_UNMATCH  = 3'd2;
   localparam logic [2:0] ERR_COMMA    = 3'd3;
   localparam logic [2:0] ERR_UNCLOSED = 3'd4;
   localparam logic [2:0] ERR_OVERFLOW = 3'd5;

   // precedence levels
   localparam logic [2:0] ADD_SUB   = 3'd2;
   localparam logic [2:0] MUL_DIV   = 3'd3;
   localparam logic [2:0] POW       = 3'd4;
   localparam logic [2:0] FUNC_PREC = 3'd6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_PUSH2,
      S_DECIDE,
      S_TAIL,
      S_FUNC,
      S_FIN
   } seq_state_type;

   typedef struct packed {
      logic       we;
      logic [3:0] data;
   } stack_wr_type;

   typedef struct packed {
      logic       have;
      logic       is_op;
      logic [2:0] prec;
      logic [3:0] top;
   } pop_req_type;

   function automatic logic [2:0] prec_of(input logic [3:0] code);
      logic [2:0] p;
      case (code) inside
         RPN_ADD, RPN_SUB: p = ADD_SUB;
         RPN_MUL, RPN_DIV: p = MUL_DIV;
         RPN_POW:          p = POW;
         default:          p = FUNC_PREC;
      endcase
      return p;
   endfunction

   function automatic logic [3:0] rpn_of_op(input logic [2:0] op);
      return {1'b0, op} + RPN_ADD;
   endfunction

endpackage

// ===== rtl/infix_to_rpn_converter.sv =====
// Top level of the infix to reverse Polish converter.
// Instantiates i2r_seq, i2r_pop_unit and i2r_stack; depends on i2r_pkg.
//
// Usage:
//   req channel: one lexed token per word. req_tuser carries the action; the
//   other token fields sit in req_tdata. The block takes a word only when idle.
//   rsp channel: one word per emitted RPN token, or one empty word when a
//   token emits nothing. rsp_tlast marks the final word caused by a token;
//   an error shows on that final word, and the stack is then cleared.
//   Sequence: an operand, an open and an operator that is ignored or refused
//   give their word straight from the start state; a builtin function pushes
//   itself and then its marker. Other operators, closes, commas and end pop
//   stack entries one at a time; a close then drops its marker, and an error
//   or a released function follows the popped tokens as a final word. The next
//   word is taken once the last result word is loaded into the result register.
//   Reset: synchronous, active high; clears the stack level and sets the
//   block to expect an operand. Stack contents need no clearing.
//   Stall: the result register holds its word while rsp_tready is low, and
//   the sequencer waits before producing the next word.
module infix_to_rpn_converter #(
   parameter int STACK_DEPTH = i2r_pkg::STACK_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [2:0] op_code, [5:3] func_code, [69:6] const_bits, [85:70] name_ref
   input  logic [i2r_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [3:0] action
   input  logic [i2r_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [63:0] out_const, [79:64] out_ref, [82:80] error_code, [83] expecting_operand
   output logic [i2r_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [0] has_token, [4:1] rpn_code
   output logic [i2r_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   output logic                             rsp_tlast
);
   import i2r_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);

   stack_wr_type  stk_wr;
   pop_req_type   pop_req;
   logic          pop;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [3:0]    rd_data;
   logic          out_has;
   logic [3:0]    out_code;
   logic [63:0]   out_const;
   logic [15:0]   out_ref;
   logic [2:0]    out_err;
   logic          out_exp;

   i2r_seq #(
      .DEPTH(STACK_DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .in_action  (req_tuser[3:0]),
      .in_op      (req_tdata[2:0]),
      .in_func    (req_tdata[5:3]),
      .in_const   (req_tdata[69:6]),
      .in_ref     (req_tdata[85:70]),
      .rsp_tready (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_has    (out_has),
      .out_code   (out_code),
      .out_const  (out_const),
      .out_ref    (out_ref),
      .out_err    (out_err),
      .out_exp    (out_exp),
      .out_last   (rsp_tlast),
      .stk_wr     (stk_wr),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .pop_req    (pop_req),
      .pop        (pop)
   );

   i2r_pop_unit u_pop (
      .req (pop_req),
      .pop (pop)
   );

   i2r_stack #(
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr      (stk_wr),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tdata = {4'b0, out_exp, out_err, out_ref, out_const};
   assign rsp_tuser = {out_code, out_has};

endmodule

// ===== rtl/i2r_stack.sv =====
// Operator stack storage: one write port, one read port with registered data.
// Depends on i2r_pkg for the write struct.
module i2r_stack #(
   parameter int DEPTH = i2r_pkg::STACK_DEPTH_DEF
) (
   input  logic                     clock,
   input  i2r_pkg::stack_wr_type    wr,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [3:0]               rd_data
);
   import i2r_pkg::*;

   logic [3:0] mem [DEPTH];
   logic [3:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr_addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/i2r_pop_unit.sv =====
// Pop decision unit: compares the stack top against the pending operator or paren.
// Depends on i2r_pkg for the precedence table and request struct.
module i2r_pop_unit (
   input  i2r_pkg::pop_req_type req,
   output logic                 pop
);
   import i2r_pkg::*;

   logic not_marker;
   logic prec_ok;

   assign not_marker = req.have && (req.top != MARKER);
   assign prec_ok    = prec_of(req.top) >= req.prec;

   // parens, commas and end pop everything down to a marker
   assign pop = not_marker && (!req.is_op || prec_ok);

endmodule

// ===== rtl/i2r_seq.sv =====
// Sequencer: takes one token, walks the operator stack through the pop unit one
// entry a cycle unless output stalls; drives the result register. Uses i2r_pkg.
module i2r_seq #(
   parameter int DEPTH = i2r_pkg::STACK_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [3:0]               in_action,
   input  logic [2:0]               in_op,
   input  logic [2:0]               in_func,
   input  logic [63:0]              in_const,
   input  logic [15:0]              in_ref,
   input  logic                     rsp_tready,
   output logic                     out_valid,
   output logic                     out_has,
   output logic [3:0]               out_code,
   output logic [63:0]              out_const,
   output logic [15:0]              out_ref,
   output logic [2:0]               out_err,
   output logic                     out_exp,
   output logic                     out_last,
   output i2r_pkg::stack_wr_type    stk_wr,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic [3:0]               rd_data,
   output i2r_pkg::pop_req_type     pop_req,
   input  logic                     pop
);
   import i2r_pkg::*;

   localparam int LW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);
   localparam logic [LW:0]   DEPTH_X = (LW + 1)'(DEPTH);

   seq_state_type state_ff, state_in;
   logic [LW-1:0] level_ff, level_in;
   logic [LW-1:0] mcount_ff, mcount_in;
   logic          expect_ff, expect_in;
   logic          exp_fin_ff, exp_fin_in;
   logic          exp_new;
   logic [3:0]    act_ff, act_in;
   logic [2:0]    op_ff, op_in;
   logic [2:0]    fn_ff, fn_in;
   logic [63:0]   cst_ff, cst_in;
   logic [15:0]   ref_ff, ref_in;
   logic          pend_v_ff, pend_v_in;
   logic          pend_has_ff, pend_has_in;
   logic [3:0]    pend_code_ff, pend_code_in;
   logic [2:0]    pend_err_ff, pend_err_in;
   logic          rsp_v_ff, rsp_v_in;
   logic          o_has_ff, o_has_in;
   logic [3:0]    o_code_ff, o_code_in;
   logic [63:0]   o_const_ff, o_const_in;
   logic [15:0]   o_ref_ff, o_ref_in;
   logic [2:0]    o_err_ff, o_err_in;
   logic          o_exp_ff, o_exp_in;
   logic          o_last_ff, o_last_in;

   logic          out_free;
   logic          have_top;
   logic          pop_go;
   logic          func_full;
   logic          op_skip;
   logic [LW-1:0] rd_next;

   // end-of-item tail result
   logic          tail_v;
   logic          tail_has;
   logic [3:0]    tail_code;
   logic [2:0]    tail_err;
   logic          tail_clr;

   logic          em_go;
   logic          em_has;
   logic [3:0]    em_code;
   logic [63:0]   em_const;
   logic [15:0]   em_ref;
   logic [2:0]    em_err;
   logic          em_last;
   logic          fin_go;

   assign out_free  = !rsp_v_ff || rsp_tready;
   assign have_top  = level_ff != '0;
   assign pop_go    = pop && (!pend_v_ff || out_free);
   assign func_full = ({1'b0, level_ff} + (LW + 1)'(2)) > DEPTH_X;
   assign op_skip   = (op_ff > OP_MAX) || expect_ff;

   assign pop_req.have  = have_top;
   assign pop_req.is_op = act_ff == ACT_OP;
   assign pop_req.prec  = prec_of(rpn_of_op(op_ff));
   assign pop_req.top   = rd_data;

   // read the entry that will be on top next cycle
   assign rd_next = level_in - LW'(1);
   assign rd_addr = rd_next[AW-1:0];
   assign wr_addr = level_ff[AW-1:0];

   assign req_tready = state_ff == S_IDLE;

   // parser flag that this item leaves behind; known before any pop
   always_comb begin
      case (in_action)
         ACT_NUMBER, ACT_VAR, ACT_CUSTOM: exp_new = 1'b0;
         ACT_FUNC, ACT_OPEN, ACT_COMMA, ACT_END: exp_new = 1'b1;
         ACT_OP:    exp_new = (in_op > OP_MAX) ? expect_ff : 1'b1;
         ACT_CLOSE: exp_new = mcount_ff == '0;
         default:   exp_new = expect_ff;
      endcase
   end

   always_comb begin
      tail_v    = 1'b0;
      tail_has  = 1'b0;
      tail_code = RPN_CONST;
      tail_err  = ERR_NONE;
      tail_clr  = 1'b0;
      if (state_ff == S_FUNC) begin
         if (have_top && (rd_data >= RPN_FUNC_BASE)) begin
            tail_v    = 1'b1;
            tail_has  = 1'b1;
            tail_code = rd_data;
         end
      end else begin
         case (act_ff)
            ACT_OP: begin
               if (level_ff == DEPTH_L) begin
                  tail_v   = 1'b1;
                  tail_err = ERR_OVERFLOW;
                  tail_clr = 1'b1;
               end
            end
            ACT_CLOSE: begin
               if (!have_top) begin
                  tail_v   = 1'b1;
                  tail_err = ERR_UNMATCH;
                  tail_clr = 1'b1;
               end
            end
            ACT_COMMA: begin
               if (!have_top) begin
                  tail_v   = 1'b1;
                  tail_err = ERR_COMMA;
                  tail_clr = 1'b1;
               end
            end
            ACT_END: begin
               if (have_top) begin
                  tail_v   = 1'b1;
                  tail_err = ERR_UNCLOSED;
                  tail_clr = 1'b1;
               end
            end
            default: tail_v = 1'b0;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_START;
         end
         S_START: begin
            if (out_free) begin
               case (act_ff)
                  ACT_FUNC: state_in = func_full ? S_IDLE : S_PUSH2;
                  ACT_OP:   state_in = op_skip ? S_IDLE : S_DECIDE;
                  ACT_CLOSE, ACT_COMMA, ACT_END: state_in = S_DECIDE;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_PUSH2: begin
            if (out_free) state_in = S_IDLE;
         end
         S_DECIDE: begin
            if (!pop) state_in = S_TAIL;
         end
         S_TAIL: begin
            if ((act_ff == ACT_CLOSE) && have_top) begin
               state_in = S_FUNC;
            end else if (out_free) begin
               state_in = (pend_v_ff && tail_v) ? S_FIN : S_IDLE;
            end
         end
         S_FUNC: begin
            if (out_free) state_in = (pend_v_ff && tail_v) ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      level_in     = level_ff;
      mcount_in    = mcount_ff;
      expect_in    = expect_ff;
      exp_fin_in   = exp_fin_ff;
      act_in       = act_ff;
      op_in        = op_ff;
      fn_in        = fn_ff;
      cst_in       = cst_ff;
      ref_in       = ref_ff;
      pend_v_in    = pend_v_ff;
      pend_has_in  = pend_has_ff;
      pend_code_in = pend_code_ff;
      pend_err_in  = pend_err_ff;
      stk_wr.we    = 1'b0;
      stk_wr.data  = MARKER;
      em_go        = 1'b0;
      em_has       = 1'b0;
      em_code      = RPN_CONST;
      em_const     = '0;
      em_ref       = '0;
      em_err       = ERR_NONE;
      em_last      = 1'b1;
      fin_go       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               act_in     = in_action;
               op_in      = in_op;
               fn_in      = in_func;
               cst_in     = in_const;
               ref_in     = in_ref;
               exp_fin_in = exp_new;
            end
         end
         S_START: begin
            if (out_free) begin
               case (act_ff)
                  ACT_NUMBER: begin
                     em_go    = 1'b1;
                     em_has   = 1'b1;
                     em_code  = RPN_CONST;
                     em_const = cst_ff;
                  end
                  ACT_VAR: begin
                     em_go   = 1'b1;
                     em_has  = 1'b1;
                     em_code = RPN_VAR;
                     em_ref  = ref_ff;
                  end
                  ACT_CUSTOM: begin
                     em_go   = 1'b1;
                     em_has  = 1'b1;
                     em_code = RPN_CUSTOM;
                     em_ref  = ref_ff;
                  end
                  ACT_FUNC: begin
                     if (func_full) begin
                        em_go     = 1'b1;
                        em_err    = ERR_OVERFLOW;
                        level_in  = '0;
                        mcount_in = '0;
                     end else begin
                        stk_wr.we   = 1'b1;
                        stk_wr.data = RPN_FUNC_BASE + {1'b0, fn_ff};
                        level_in    = level_ff + LW'(1);
                     end
                  end
                  ACT_OP: begin
                     if (op_ff > OP_MAX) begin
                        em_go = 1'b1;
                     end else if (expect_ff) begin
                        em_go     = 1'b1;
                        em_err    = ERR_OPERATOR;
                        level_in  = '0;
                        mcount_in = '0;
                     end
                  end
                  ACT_OPEN: begin
                     em_go = 1'b1;
                     if (level_ff == DEPTH_L) begin
                        em_err    = ERR_OVERFLOW;
                        level_in  = '0;
                        mcount_in = '0;
                     end else begin
                        stk_wr.we   = 1'b1;
                        stk_wr.data = MARKER;
                        level_in    = level_ff + LW'(1);
                        mcount_in   = mcount_ff + LW'(1);
                     end
                  end
                  ACT_CLOSE, ACT_COMMA, ACT_END: em_go = 1'b0;
                  default: em_go = 1'b1;
               endcase
            end
         end
         S_PUSH2: begin
            if (out_free) begin
               em_go       = 1'b1;
               stk_wr.we   = 1'b1;
               stk_wr.data = MARKER;
               level_in    = level_ff + LW'(1);
               mcount_in   = mcount_ff + LW'(1);
            end
         end
         S_DECIDE: begin
            if (pop_go) begin
               // hold the popped token until we know whether more follow
               if (pend_v_ff) begin
                  em_go   = 1'b1;
                  em_has  = pend_has_ff;
                  em_code = pend_code_ff;
                  em_err  = pend_err_ff;
                  em_last = 1'b0;
               end
               pend_v_in    = 1'b1;
               pend_has_in  = 1'b1;
               pend_code_in = rd_data;
               pend_err_in  = ERR_NONE;
               level_in     = level_ff - LW'(1);
            end
         end
         S_TAIL: begin
            if ((act_ff == ACT_CLOSE) && have_top) begin
               // drop the marker, then look beneath it for a function
               level_in  = level_ff - LW'(1);
               mcount_in = mcount_ff - LW'(1);
            end else if (out_free) begin
               fin_go = 1'b1;
               if ((act_ff == ACT_OP) && !tail_v) begin
                  stk_wr.we   = 1'b1;
                  stk_wr.data = rpn_of_op(op_ff);
                  level_in    = level_ff + LW'(1);
               end
            end
         end
         S_FUNC: begin
            if (out_free) begin
               fin_go = 1'b1;
               if (tail_v) level_in = level_ff - LW'(1);
            end
         end
         S_FIN: begin
            if (out_free) begin
               em_go     = 1'b1;
               em_has    = pend_has_ff;
               em_code   = pend_code_ff;
               em_err    = pend_err_ff;
               pend_v_in = 1'b0;
            end
         end
         default: em_go = 1'b0;
      endcase

      if (fin_go) begin
         em_go = 1'b1;
         if (tail_clr) begin
            level_in  = '0;
            mcount_in = '0;
         end
         if (pend_v_ff) begin
            em_has  = pend_has_ff;
            em_code = pend_code_ff;
            em_err  = pend_err_ff;
            em_last = !tail_v;
            if (tail_v) begin
               pend_has_in  = tail_has;
               pend_code_in = tail_code;
               pend_err_in  = tail_err;
            end else begin
               pend_v_in = 1'b0;
            end
         end else if (tail_v) begin
            em_has  = tail_has;
            em_code = tail_code;
            em_err  = tail_err;
         end
      end

      // result register: drop a taken word, load a new one
      rsp_v_in   = rsp_v_ff && !rsp_tready;
      o_has_in   = o_has_ff;
      o_code_in  = o_code_ff;
      o_const_in = o_const_ff;
      o_ref_in   = o_ref_ff;
      o_err_in   = o_err_ff;
      o_exp_in   = o_exp_ff;
      o_last_in  = o_last_ff;
      if (em_go) begin
         rsp_v_in   = 1'b1;
         o_has_in   = em_has;
         o_code_in  = em_code;
         o_const_in = em_const;
         o_ref_in   = em_ref;
         o_err_in   = em_err;
         o_exp_in   = exp_fin_ff;
         o_last_in  = em_last;
         expect_in  = exp_fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         level_ff  <= '0;
         mcount_ff <= '0;
         expect_ff <= 1'b1;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         level_ff  <= level_in;
         mcount_ff <= mcount_in;
         expect_ff <= expect_in;
         pend_v_ff <= pend_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_fin_ff   <= exp_fin_in;
      act_ff       <= act_in;
      op_ff        <= op_in;
      fn_ff        <= fn_in;
      cst_ff       <= cst_in;
      ref_ff       <= ref_in;
      pend_has_ff  <= pend_has_in;
      pend_code_ff <= pend_code_in;
      pend_err_ff  <= pend_err_in;
      o_has_ff     <= o_has_in;
      o_code_ff    <= o_code_in;
      o_const_ff   <= o_const_in;
      o_ref_ff     <= o_ref_in;
      o_err_ff     <= o_err_in;
      o_exp_ff     <= o_exp_in;
      o_last_ff    <= o_last_in;
   end

   assign out_valid = rsp_v_ff;
   assign out_has   = o_has_ff;
   assign out_code  = o_code_ff;
   assign out_const = o_const_ff;
   assign out_ref   = o_ref_ff;
   assign out_err   = o_err_ff;
   assign out_exp   = o_exp_ff;
   assign out_last  = o_last_ff;

endmodule

// ===== rtl/i2r_checker.sv =====
// Port-level checks for the converter, attached by bind.
// Depends on i2r_pkg for stream widths and error codes.
module i2r_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [i2r_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [i2r_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input logic                             rsp_tlast
);
   import i2r_pkg::*;

   // a word that waits keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // one token at a time: ready drops right after a word is taken
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a token is in flight");

   // an error only rides on the final, empty word
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[82:80] != ERR_NONE) |-> rsp_tlast && !rsp_tuser[0])
      else $error("error code on a non-final or token word");

   // an empty word carries no code, constant or reference
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tuser[4:1] == RPN_CONST) &&
      (rsp_tdata[79:0] == '0))
      else $error("empty word carries payload");

endmodule

bind infix_to_rpn_converter i2r_checker u_chk (.*);
